/* src/assert_macros.svh */
// Assertion helper macros shared by checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("check failed");
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("check failed");
`endif

/* src/qle_pkg.sv */
// ----------------------------------------------------------------------------
// qle_pkg
// Types and constants for the quota limit enforcer.
// ----------------------------------------------------------------------------
package qle_pkg;
   localparam int ACCOUNTS = 256;
   localparam int QUOTA_TYPES = 2;
   localparam int ACC_W = $clog2(ACCOUNTS);
   localparam int ENTRIES = 2 * ACCOUNTS;
   localparam int ENT_W = $clog2(ENTRIES);
   localparam logic [31:0] GRACE_RST = 32'd604800;

   localparam logic [1:0] OP_CHARGE = 2'd0;
   localparam logic [1:0] OP_SETLIM = 2'd1;
   localparam logic [1:0] OP_SETUSE = 2'd2;
   localparam logic [1:0] OP_READ   = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_HARD  = 2'd1;
   localparam logic [1:0] ST_GRACE = 2'd2;

   localparam logic [1:0] NT_NONE  = 2'd0;
   localparam logic [1:0] NT_HARD  = 2'd1;
   localparam logic [1:0] NT_SOFT  = 2'd2;
   localparam logic [1:0] NT_GRACE = 2'd3;

   localparam logic CSR_BLOCK_GRACE = 1'b0;
   localparam logic CSR_INODE_GRACE = 1'b1;

   typedef struct packed {
      logic [1:0]  op;
      logic        resource;
      logic [7:0]  account_a;
      logic        account_a_valid;
      logic [7:0]  account_b;
      logic        account_b_valid;
      logic signed [31:0] change;
      logic        enforce;
      logic        owner_match;
      logic [31:0] first_value;
      logic [31:0] second_value;
      logic [31:0] now;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [1:0]  notice;
      logic [31:0] usage;
      logic [31:0] soft_limit;
      logic [31:0] hard_limit;
      logic [31:0] deadline;
      logic        over_flag;
   } rsp_type;

   typedef struct packed {
      logic [31:0] usage;
      logic [31:0] soft_lim;
      logic [31:0] hard;
      logic [31:0] deadline;
      logic        over;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);
endpackage

/* src/qle_store.sv */
// ----------------------------------------------------------------------------
// qle_store
// Account table: one write, one registered read port, clearing sweep.
// ----------------------------------------------------------------------------
module qle_store (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [qle_pkg::ENT_W-1:0] rd_addr,
   output qle_pkg::entry_type      rd_data,
   input  logic                    wr_en,
   input  logic [qle_pkg::ENT_W-1:0] wr_addr,
   input  qle_pkg::entry_type      wr_data,
   output logic                    clr_busy
);
   import qle_pkg::*;

   entry_type mem [ENTRIES];
   logic [ENT_W:0] clr_ff, clr_in;

   assign clr_busy = ~clr_ff[ENT_W];
   assign clr_in = clr_busy ? clr_ff + 1'b1 : clr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy) begin
         mem[clr_ff[ENT_W-1:0]] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

/* src/qle_calc.sv */
// ----------------------------------------------------------------------------
// qle_calc
// Per-entry update logic for one read-modify-write step.
// ----------------------------------------------------------------------------
module qle_calc (
   input  qle_pkg::req_type   req,
   input  qle_pkg::entry_type cur,
   input  logic [31:0]        grace,
   input  logic               check,
   output qle_pkg::entry_type nxt,
   output logic [1:0]         status,
   output logic [1:0]         notice
);
   import qle_pkg::*;

   logic [32:0] sum;
   logic [32:0] dif;
   logic [31:0] mag;
   logic [31:0] dl_new;
   logic        ge_hard, ge_soft;

   always_comb begin
      mag = 32'(-req.change);
      sum = {1'b0, cur.usage} + {1'b0, req.change};
      dif = {1'b0, cur.usage} - {1'b0, mag};
      dl_new = req.now + grace;
      ge_hard = sum >= {1'b0, cur.hard};
      ge_soft = sum >= {1'b0, cur.soft_lim};
      nxt = cur;
      status = ST_OK;
      notice = NT_NONE;
      case (req.op)
         OP_CHARGE: begin
            if (req.change[31]) begin
               nxt.usage = dif[32] ? 32'd0 : dif[31:0];
               nxt.over = 1'b0;
            end else if (req.change != 0) begin
               if (check) begin
                  if (cur.hard != 0 && ge_hard) begin
                     status = ST_HARD;
                     if (!cur.over && req.owner_match) begin
                        notice = NT_HARD;
                        nxt.over = 1'b1;
                     end
                  end else if (cur.soft_lim != 0 && ge_soft) begin
                     if (cur.usage < cur.soft_lim) begin
                        nxt.deadline = dl_new;
                        if (req.owner_match) notice = NT_SOFT;
                     end else if (req.now > cur.deadline) begin
                        status = ST_GRACE;
                        if (!cur.over && req.owner_match) begin
                           notice = NT_GRACE;
                           nxt.over = 1'b1;
                        end
                     end
                  end
               end else begin
                  nxt.usage = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
               end
            end
         end
         OP_SETLIM: begin
            if (req.first_value != 0 && cur.usage >= req.first_value &&
                (cur.soft_lim == 0 || cur.usage < cur.soft_lim)) begin
               nxt.deadline = dl_new;
            end
            nxt.soft_lim = req.first_value;
            nxt.hard = req.second_value;
            if (cur.usage < req.first_value) nxt.over = 1'b0;
         end
         OP_SETUSE: begin
            if (cur.soft_lim != 0 && cur.usage < cur.soft_lim &&
                req.first_value >= cur.soft_lim) begin
               nxt.deadline = dl_new;
            end
            nxt.usage = req.first_value;
            if (req.first_value < cur.soft_lim) nxt.over = 1'b0;
         end
         default: begin
         end
      endcase
   end
endmodule

/* src/quota_limit_enforcer_core.sv */
// ----------------------------------------------------------------------------
// quota_limit_enforcer_core
// Disk-quota style soft/hard limiter with grace, table in one memory.
// ----------------------------------------------------------------------------
// Flow: entry passes (read, update and write back), then a read of entry a
//   and strobe; one pass per account; positive enforced charges check first.
// Throughput: one request at a time; busy high through the response strobe,
//   next request taken in the cycle after it.
// Reset: synchronous; then a clearing sweep of every entry, busy high, config taken.
// Response is a single-cycle strobe; the receiver cannot stall.
module quota_limit_enforcer_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  qle_pkg::req_type req_data,
   output logic             rsp_valid,
   output qle_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [31:0]      csr_wdata
);
   import qle_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_CALC = 3'd2;
   localparam logic [2:0] S_LAST = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0] state_ff, state_in;
   // pass: bit1 = apply phase, bit0 = account b
   logic [1:0] pass_ff, pass_in;
   req_type    req_ff;
   logic [1:0] status_ff, status_in, notice_ff, notice_in;
   logic [31:0] bgrace_ff, igrace_ff;
   logic        clr_busy;

   logic [ENT_W-1:0] ent_a, ent_b, addr;
   entry_type rd, nxt;
   logic [1:0] c_status, c_notice;
   logic part_a, part_b, part_cur, check, wr_en;
   logic charge_chk, last;

   assign ent_a = {req_ff.resource, req_ff.account_a[ACC_W-1:0]};
   assign ent_b = {req_ff.resource, req_ff.account_b[ACC_W-1:0]};
   assign addr  = pass_ff[0] ? ent_b : ent_a;
   assign part_a = req_ff.op != OP_CHARGE || req_ff.account_a_valid;
   assign part_b = req_ff.op == OP_CHARGE && QUOTA_TYPES > 1 && req_ff.account_b_valid;
   assign part_cur = pass_ff[0] ? part_b : part_a;
   // positive enforced charges do a check phase first
   assign charge_chk = req_ff.op == OP_CHARGE && !req_ff.change[31] &&
                       req_ff.change != 0 && req_ff.enforce;
   assign check = !pass_ff[1];
   assign wr_en = state_ff == S_CALC && part_cur && status_ff == ST_OK;

   qle_store u_store (
      .clock(clock), .reset(reset), .rd_addr(addr), .rd_data(rd),
      .wr_en(wr_en), .wr_addr(addr), .wr_data(nxt), .clr_busy(clr_busy));

   qle_calc u_calc (
      .req(req_ff), .cur(rd), .grace(req_ff.resource ? igrace_ff : bgrace_ff),
      .check(check), .nxt(nxt), .status(c_status), .notice(c_notice));

   assign last = pass_ff[0] || req_ff.op != OP_CHARGE;

   always_comb begin
      state_in = state_ff;
      pass_in = pass_ff;
      status_in = status_ff;
      notice_in = notice_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start && !clr_busy) begin
               state_in = S_READ;
               status_in = ST_OK;
               notice_in = NT_NONE;
               pass_in = {!(req_data.op == OP_CHARGE && !req_data.change[31] &&
                            req_data.change != 0 && req_data.enforce), 1'b0};
            end
         end
         S_READ: state_in = S_CALC;
         S_CALC: begin
            state_in = S_READ;
            if (part_cur && status_ff == ST_OK && check) begin
               status_in = c_status;
               if (c_notice != NT_NONE) notice_in = c_notice;
            end
            if (!last) begin
               pass_in = {pass_ff[1], 1'b1};
            end else if (!pass_ff[1] && charge_chk && status_in == ST_OK) begin
               pass_in = 2'b10;
            end else begin
               pass_in = 2'b00;
               state_in = S_LAST;
            end
         end
         // entry a read back after the final write lands
         S_LAST: state_in = S_DONE;
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pass_ff <= '0;
         status_ff <= ST_OK;
         notice_ff <= NT_NONE;
         bgrace_ff <= GRACE_RST;
         igrace_ff <= GRACE_RST;
      end else begin
         state_ff <= state_in;
         pass_ff <= pass_in;
         status_ff <= status_in;
         notice_ff <= notice_in;
         if (csr_we && csr_index == CSR_BLOCK_GRACE) bgrace_ff <= csr_wdata;
         if (csr_we && csr_index == CSR_INODE_GRACE) igrace_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) req_ff <= req_data;
   end

   // S_DONE: rd holds entry a as read during S_LAST
   assign busy = state_ff != S_IDLE || clr_busy;
   assign rsp_valid = state_ff == S_DONE;
   assign rsp_data = '{status: status_ff, notice: notice_ff, usage: rd.usage,
                       soft_limit: rd.soft_lim, hard_limit: rd.hard,
                       deadline: rd.deadline, over_flag: rd.over};
endmodule

/* src/qle_checker.sv */
// ----------------------------------------------------------------------------
// qle_checker
// Port-level checks on the enforcer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module qle_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input qle_pkg::rsp_type rsp_data
);
   import qle_pkg::*;

   `CHK_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   `CHK_IMPLY(a_rsp_busy, clock, reset, rsp_valid, busy)
   `CHK_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
   `CHK_IMPLY(a_status_ok, clock, reset, rsp_valid, rsp_data.status != 2'd3)
endmodule

bind quota_limit_enforcer_core qle_checker u_chk (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_data(rsp_data));

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ============================================================================
// Quota limit enforcer core testbench
// Drives requests through the start/busy handshake: a directed table of
// corner cases first, then random traffic that mostly works a small set of
// accounts. A behavioral copy of the quota table predicts every response,
// and each response is checked field by field against the oldest prediction.
// ============================================================================
module tb_top;
   import qle_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_REQUESTS = 400;
   localparam int CALM_REQUESTS = 60;   // last stretch: no sender gaps

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type req_data;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_we;
   logic csr_index;
   logic [31:0] csr_wdata;

   quota_limit_enforcer_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Shadow of the quota table and grace registers.
   logic [31:0] shadow_usage [ENTRIES];
   logic [31:0] shadow_soft [ENTRIES];
   logic [31:0] shadow_hard [ENTRIES];
   logic [31:0] shadow_deadline [ENTRIES];
   logic shadow_over [ENTRIES];
   logic [31:0] shadow_block_grace;
   logic [31:0] shadow_inode_grace;

   rsp_type pending_rsp[$];
   int errors = 0;
   int idle_cycles = 0;

   // Directed rows: request plus an optional hand-written response.
   typedef struct {
      req_type req;
      bit      typed;
      rsp_type rsp;
   } vector_type;
   vector_type vectors[$];

   function automatic int unsigned entry_index(logic res, logic [7:0] acct);
      return int'(res) * ACCOUNTS + (int'(acct) % ACCOUNTS);
   endfunction

   function automatic logic [31:0] grace_for(logic res);
      return res ? shadow_inode_grace : shadow_block_grace;
   endfunction

   // One account check for a positive charge under enforcement.
   function automatic logic [1:0] check_account(int unsigned e, logic res,
         longint delta, logic owner, logic [31:0] now, ref logic [1:0] notice);
      longint cur;
      longint nv;
      cur = longint'(shadow_usage[e]);
      nv = cur + delta;
      if (shadow_hard[e] != 0 && nv >= longint'(shadow_hard[e])) begin
         if (!shadow_over[e] && owner) begin
            notice = NT_HARD;
            shadow_over[e] = 1'b1;
         end
         return ST_HARD;
      end
      if (shadow_soft[e] != 0 && nv >= longint'(shadow_soft[e])) begin
         if (cur < longint'(shadow_soft[e])) begin
            shadow_deadline[e] = now + grace_for(res);
            if (owner) notice = NT_SOFT;
            return ST_OK;
         end
         if (now > shadow_deadline[e]) begin
            if (!shadow_over[e] && owner) begin
               notice = NT_GRACE;
               shadow_over[e] = 1'b1;
            end
            return ST_GRACE;
         end
      end
      return ST_OK;
   endfunction

   function automatic rsp_type predict_quota(req_type r);
      rsp_type o;
      int unsigned ent[2];
      logic part[2];
      longint delta;
      longint nv;
      logic [1:0] status;
      logic [1:0] notice;
      int unsigned ea;
      logic [31:0] cur;
      logic [31:0] soft_now;
      status = ST_OK;
      notice = NT_NONE;
      ent[0] = entry_index(r.resource, r.account_a);
      ent[1] = entry_index(r.resource, r.account_b);
      part[0] = r.account_a_valid;
      part[1] = (QUOTA_TYPES > 1) && r.account_b_valid;
      ea = ent[0];
      delta = longint'(r.change);
      case (r.op)
         OP_CHARGE: begin
            if (delta < 0) begin
               for (int i = 0; i < 2; i++) begin
                  if (part[i]) begin
                     nv = longint'(shadow_usage[ent[i]]) + delta;
                     shadow_usage[ent[i]] = (nv < 0) ? 32'd0 : nv[31:0];
                     shadow_over[ent[i]] = 1'b0;
                  end
               end
            end else if (delta > 0) begin
               if (r.enforce) begin
                  for (int i = 0; i < 2 && status == ST_OK; i++) begin
                     if (part[i])
                        status = check_account(ent[i], r.resource, delta,
                                               r.owner_match, r.now, notice);
                  end
               end
               if (status == ST_OK) begin
                  for (int i = 0; i < 2; i++) begin
                     if (part[i]) begin
                        nv = longint'(shadow_usage[ent[i]]) + delta;
                        shadow_usage[ent[i]] = (nv > 64'hFFFF_FFFF) ?
                                               32'hFFFF_FFFF : nv[31:0];
                     end
                  end
               end
            end
         end
         OP_SETLIM: begin
            cur = shadow_usage[ea];
            if (r.first_value != 0 && cur >= r.first_value &&
                (shadow_soft[ea] == 0 || cur < shadow_soft[ea]))
               shadow_deadline[ea] = r.now + grace_for(r.resource);
            shadow_soft[ea] = r.first_value;
            shadow_hard[ea] = r.second_value;
            if (cur < r.first_value) shadow_over[ea] = 1'b0;
         end
         OP_SETUSE: begin
            soft_now = shadow_soft[ea];
            if (soft_now != 0 && shadow_usage[ea] < soft_now && r.first_value >= soft_now)
               shadow_deadline[ea] = r.now + grace_for(r.resource);
            shadow_usage[ea] = r.first_value;
            if (r.first_value < soft_now) shadow_over[ea] = 1'b0;
         end
         default: ;
      endcase
      o.status = status;
      o.notice = notice;
      o.usage = shadow_usage[ea];
      o.soft_limit = shadow_soft[ea];
      o.hard_limit = shadow_hard[ea];
      o.deadline = shadow_deadline[ea];
      o.over_flag = shadow_over[ea];
      return o;
   endfunction

   // Response checker and watchdog, sampled at the rising edge.
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset) begin
         if ((start && !busy) || rsp_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
         if (rsp_valid) begin
            if (pending_rsp.size() == 0) begin
               $error("response with no request outstanding");
               errors++;
            end else begin
               exp_rsp = pending_rsp.pop_front();
               if (rsp_data.status !== exp_rsp.status) begin
                  $error("status exp %0d got %0d", exp_rsp.status, rsp_data.status);
                  errors++;
               end
               if (rsp_data.notice !== exp_rsp.notice) begin
                  $error("notice exp %0d got %0d", exp_rsp.notice, rsp_data.notice);
                  errors++;
               end
               if (rsp_data.usage !== exp_rsp.usage) begin
                  $error("usage exp %0h got %0h", exp_rsp.usage, rsp_data.usage);
                  errors++;
               end
               if (rsp_data.soft_limit !== exp_rsp.soft_limit) begin
                  $error("soft_limit exp %0h got %0h", exp_rsp.soft_limit,
                         rsp_data.soft_limit);
                  errors++;
               end
               if (rsp_data.hard_limit !== exp_rsp.hard_limit) begin
                  $error("hard_limit exp %0h got %0h", exp_rsp.hard_limit,
                         rsp_data.hard_limit);
                  errors++;
               end
               if (rsp_data.deadline !== exp_rsp.deadline) begin
                  $error("deadline exp %0h got %0h", exp_rsp.deadline,
                         rsp_data.deadline);
                  errors++;
               end
               if (rsp_data.over_flag !== exp_rsp.over_flag) begin
                  $error("over_flag exp %0b got %0b", exp_rsp.over_flag,
                         rsp_data.over_flag);
                  errors++;
               end
            end
         end
      end
   end

   // Present one request, hold it until taken, then predict its response.
   // start stays high across back-to-back requests.
   task automatic issue_request(req_type r, bit typed, rsp_type typed_rsp,
                                bit allow_gap);
      rsp_type p;
      if (allow_gap && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      // accepted at this edge
      p = predict_quota(r);
      if (typed && p !== typed_rsp) begin
         $error("directed row disagrees with shadow table: exp %0h calc %0h",
                typed_rsp, p);
         errors++;
      end
      pending_rsp.push_back(typed ? typed_rsp : p);
   endtask

   task automatic drain_responses();
      start <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // Grace writes only while idle; csr_index is the register name.
   task automatic write_grace(logic idx, logic [31:0] value);
      drain_responses();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_BLOCK_GRACE) shadow_block_grace = value;
      else shadow_inode_grace = value;
   endtask

   function automatic req_type blank_req();
      req_type r;
      r = '0;
      r.account_a_valid = 1'b1;
      r.enforce = 1'b1;
      r.owner_match = 1'b1;
      return r;
   endfunction

   function automatic void add_row(req_type r, bit typed, rsp_type rsp);
      vector_type v;
      v.req = r;
      v.typed = typed;
      v.rsp = rsp;
      vectors.push_back(v);
   endfunction

   task automatic build_directed();
      req_type r;
      rsp_type e;
      // read after reset: all zero
      r = blank_req(); r.op = OP_READ; r.account_a = 8'hFF; r.resource = 1'b1;
      e = '0; add_row(r, 1, e);
      // limits on account 5 blocks: soft 100, hard 200
      r = blank_req(); r.op = OP_SETLIM; r.account_a = 8'd5;
      r.first_value = 100; r.second_value = 200; r.now = 1000;
      e = '0; e.soft_limit = 100; e.hard_limit = 200; add_row(r, 1, e);
      // soft crossing starts grace, notice soft warning
      r = blank_req(); r.account_a = 8'd5; r.change = 150; r.now = 1000;
      e.usage = 150; e.notice = NT_SOFT; e.deadline = 1000 + GRACE_RST;
      add_row(r, 1, e);
      // reaching hard limit denies with hard notice, flag set
      r.change = 50; e.status = ST_HARD; e.notice = NT_HARD; e.over_flag = 1;
      add_row(r, 1, e);
      // same again: flag already set, no notice
      e.notice = NT_NONE; add_row(r, 1, e);
      // grace expired denies
      r.change = 1; r.now = 32'hFFFF_FFFF; e.status = ST_GRACE; add_row(r, 1, e);
      // release clamps at zero and clears flag
      r.change = 32'sh8000_0000; e = '{status: ST_OK, notice: NT_NONE, usage: 0,
         soft_limit: 100, hard_limit: 200, deadline: 1000 + GRACE_RST, over_flag: 0};
      add_row(r, 1, e);
      // zero change does nothing
      r.change = 0; add_row(r, 1, e);
      // no enforcement: saturating charge
      r = blank_req(); r.account_a = 8'd7; r.enforce = 0;
      r.change = 32'sh7FFF_FFFF; add_row(r, 0, e);
      add_row(r, 0, e); add_row(r, 0, e);
      // set usage crossing soft on inode entry with same account twice
      r = blank_req(); r.op = OP_SETLIM; r.resource = 1; r.account_a = 8'd9;
      r.first_value = 10; r.second_value = 0; r.now = 32'hFFFF_FFF0;
      add_row(r, 0, e);
      r.op = OP_SETUSE; r.first_value = 32'hFFFF_FFFF; add_row(r, 0, e);
      r.op = OP_SETUSE; r.first_value = 0; add_row(r, 0, e);
      r = blank_req(); r.resource = 1; r.account_a = 8'd9; r.account_b = 8'd9;
      r.account_b_valid = 1; r.change = 6; r.now = 5; add_row(r, 0, e);
      r.owner_match = 0; add_row(r, 0, e);
      // group account denies after user passed
      r = blank_req(); r.op = OP_SETLIM; r.account_a = 8'd20;
      r.first_value = 1; r.second_value = 3; add_row(r, 0, e);
      r = blank_req(); r.account_a = 8'd21; r.account_b = 8'd20;
      r.account_b_valid = 1; r.change = 3; add_row(r, 0, e);
      r.account_a_valid = 0; r.change = 1; add_row(r, 0, e);
      // set limits on an entry still at zero usage
      r = blank_req(); r.op = OP_SETLIM; r.account_a = 8'd21;
      r.first_value = 2; r.second_value = 32'hFFFF_FFFF; r.now = 77;
      add_row(r, 0, e);
      r.op = OP_READ; add_row(r, 0, e);
   endtask

   function automatic req_type random_request();
      req_type r;
      logic [31:0] lim;
      r.op = $urandom_range(0, 9) < 6 ? OP_CHARGE : 2'($urandom_range(1, 3));
      r.resource = 1'($urandom_range(0, 1));
      // mostly a handful of accounts so that state builds up
      r.account_a = $urandom_range(0, 4) != 0 ? 8'($urandom_range(0, 7)) : 8'($urandom);
      r.account_b = $urandom_range(0, 4) != 0 ? 8'($urandom_range(0, 7)) : 8'($urandom);
      r.account_a_valid = $urandom_range(0, 7) != 0;
      r.account_b_valid = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
         0: r.change = $urandom;
         1: r.change = -int'($urandom_range(0, 300));
         default: r.change = $urandom_range(0, 120);
      endcase
      r.enforce = $urandom_range(0, 5) != 0;
      r.owner_match = $urandom_range(0, 3) != 0;
      lim = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 600);
      r.first_value = lim;
      r.second_value = $urandom_range(0, 2) == 0 ? 32'd0 :
                       ($urandom_range(0, 3) == 0 ? $urandom : lim + $urandom_range(0, 400));
      r.now = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2000000);
      return r;
   endfunction

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = CSR_BLOCK_GRACE;
      csr_wdata = '0;
      shadow_block_grace = GRACE_RST;
      shadow_inode_grace = GRACE_RST;
      for (int i = 0; i < ENTRIES; i++) begin
         shadow_usage[i] = '0;
         shadow_soft[i] = '0;
         shadow_hard[i] = '0;
         shadow_deadline[i] = '0;
         shadow_over[i] = 1'b0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      build_directed();
      foreach (vectors[i])
         issue_request(vectors[i].req, vectors[i].typed, vectors[i].rsp, 1);

      // random phases over several grace settings, extremes included
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               write_grace(CSR_BLOCK_GRACE, 32'd0);
               write_grace(CSR_INODE_GRACE, 32'hFFFF_FFFF);
            end
            1: begin
               write_grace(CSR_BLOCK_GRACE, 32'hFFFF_FFFF);
               write_grace(CSR_INODE_GRACE, 32'd0);
            end
            2: begin
               write_grace(CSR_BLOCK_GRACE, $urandom);
               write_grace(CSR_INODE_GRACE, $urandom_range(1, 1000));
            end
            default: begin
               write_grace(CSR_BLOCK_GRACE, GRACE_RST);
               write_grace(CSR_INODE_GRACE, GRACE_RST);
            end
         endcase
         for (int n = 0; n < RANDOM_REQUESTS / 4; n++)
            issue_request(random_request(), 0, '0,
                          !(phase == 3 && n >= RANDOM_REQUESTS / 4 - CALM_REQUESTS));
      end

      drain_responses();
      repeat (20) @(posedge clock);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
